// File: sv/fhcc_pkg.sv
// Shared constants and types for the file handle clock cache.
package fhcc_pkg;

   // Result field widths
   localparam int SLOT_OUT_W   = 4;
   localparam int TYPE_OUT_W   = 4;
   localparam int NUMBER_OUT_W = 36;
   localparam int OFFSET_OUT_W = 24;

   // Use flag of one slot
   typedef logic [1:0] flag_type;

   localparam flag_type FLAG_UNUSED = 2'd1;
   localparam flag_type FLAG_USED   = 2'd2;

endpackage

// File: sv/file_handle_clock_cache.sv
// File handle clock cache: key lookup, empty-slot search and second-chance eviction.
// One slot per cycle is examined through the single entry memory read port and one key
// comparator; busy stays high until the result is strobed, and the next item can be
// accepted at the edge that takes the result. Reset (synchronous): all slots empty, hand
// at slot 0, no result.
module file_handle_clock_cache
   import fhcc_pkg::*;
#(
   parameter int SLOTS       = 16,
   parameter int TYPE_BITS   = 4,
   parameter int NUMBER_BITS = 36,
   parameter int OFFSET_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [TYPE_BITS-1:0]    req_file_kind,
   input  logic [NUMBER_BITS-1:0]  req_file_number,
   input  logic [OFFSET_BITS-1:0]  req_access_offset,
   output logic                    rsp_strobe,
   output logic [SLOT_OUT_W-1:0]   rsp_slot_index,
   output logic                    rsp_was_hit,
   output logic                    rsp_open_needed,
   output logic                    rsp_evict_needed,
   output logic [TYPE_OUT_W-1:0]   rsp_evicted_type,
   output logic [NUMBER_OUT_W-1:0] rsp_evicted_number,
   output logic [OFFSET_OUT_W-1:0] rsp_offset_out
);

   localparam int IDX_W     = $clog2(SLOTS);
   localparam int KEY_W     = TYPE_BITS + NUMBER_BITS;
   localparam int ENT_W     = KEY_W + 2;
   localparam int CNT_W     = $clog2(3 * SLOTS + 1);
   localparam int SWEEP_MAX = 3 * SLOTS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HIT   = 2'd1;
   localparam logic [1:0] S_EMPTY = 2'd2;
   localparam logic [1:0] S_SWEEP = 2'd3;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(SLOTS - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   // Entry memory: {flag, key} per slot
   logic [ENT_W-1:0] ent_mem [SLOTS];

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  iss_ff, iss_in;
   logic [IDX_W-1:0]  hand_ff, hand_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [KEY_W-1:0]  key_ff;
   logic [OFFSET_BITS-1:0] ofs_ff;
   logic [ENT_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   flag_type          rd_flag;
   logic [KEY_W-1:0]  rd_key;
   logic              accept;

   // Result of the deciding cycle
   logic              done;
   logic              res_hit;
   logic              res_evict;
   logic [IDX_W-1:0]  res_slot;
   logic [KEY_W-1:0]  res_old_key;

   logic                    rsp_strobe_ff;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff;
   logic                    rsp_hit_ff;
   logic                    rsp_open_ff;
   logic                    rsp_evict_ff;
   logic [TYPE_OUT_W-1:0]   rsp_type_ff;
   logic [NUMBER_OUT_W-1:0] rsp_number_ff;
   logic [OFFSET_OUT_W-1:0] rsp_offset_ff;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign rd_flag = rd_data_ff[ENT_W-1 -: 2];
   assign rd_key  = rd_data_ff[KEY_W-1:0];

   // Sequence the lookup, empty search and second-chance sweep
   always_comb begin
      state_in    = state_ff;
      iss_in      = iss_ff;
      hand_in     = hand_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      rd_addr     = iss_ff;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = {FLAG_USED, key_ff};
      done        = 1'b0;
      res_hit     = 1'b0;
      res_evict   = 1'b0;
      res_slot    = rd_idx_ff;
      res_old_key = rd_key;
      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (start) begin
               state_in = S_HIT;
               iss_in   = idx_next('0);
            end
         end
         S_HIT: begin
            iss_in = idx_next(iss_ff);
            if (valid_ff[rd_idx_ff] && (rd_key == key_ff)) begin
               wr_en    = 1'b1;
               done     = 1'b1;
               res_hit  = 1'b1;
               state_in = S_IDLE;
            end else if (rd_idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_EMPTY;
               cnt_in   = '0;
            end
         end
         S_EMPTY: begin
            hand_in = idx_next(hand_ff);
            if (!valid_ff[hand_ff]) begin
               wr_en             = 1'b1;
               wr_addr           = hand_ff;
               valid_in[hand_ff] = 1'b1;
               done              = 1'b1;
               res_slot          = hand_ff;
               state_in          = S_IDLE;
            end else if (cnt_ff == CNT_W'(SLOTS - 1)) begin
               // hand is back at its start: begin the sweep there
               state_in = S_SWEEP;
               rd_addr  = idx_next(hand_ff);
               iss_in   = idx_next(idx_next(hand_ff));
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_SWEEP: begin
            iss_in = idx_next(iss_ff);
            if ((cnt_ff == CNT_W'(SWEEP_MAX)) || (rd_flag == FLAG_UNUSED)) begin
               wr_en     = 1'b1;
               hand_in   = idx_next(rd_idx_ff);
               done      = 1'b1;
               res_evict = 1'b1;
               state_in  = S_IDLE;
            end else begin
               // second chance: age the slot and move on
               wr_en   = 1'b1;
               wr_data = {rd_flag - 2'd1, rd_key};
               hand_in = idx_next(rd_idx_ff);
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory port: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ent_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= ent_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hand_ff  <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         hand_ff  <= hand_in;
         valid_ff <= valid_in;
      end
   end

   // Counters and the held item
   always_ff @(posedge clock) begin
      iss_ff <= iss_in;
      cnt_ff <= cnt_in;
      if (accept) begin
         key_ff <= {req_file_kind, req_file_number};
         ofs_ff <= req_access_offset;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
      if (done) begin
         rsp_slot_ff   <= SLOT_OUT_W'(res_slot);
         rsp_hit_ff    <= res_hit;
         rsp_open_ff   <= !res_hit;
         rsp_evict_ff  <= res_evict;
         rsp_type_ff   <= res_evict ?
                          TYPE_OUT_W'(res_old_key[KEY_W-1 -: TYPE_BITS]) : '0;
         rsp_number_ff <= res_evict ?
                          NUMBER_OUT_W'(res_old_key[NUMBER_BITS-1:0]) : '0;
         rsp_offset_ff <= OFFSET_OUT_W'(ofs_ff);
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_was_hit        = rsp_hit_ff;
   assign rsp_open_needed    = rsp_open_ff;
   assign rsp_evict_needed   = rsp_evict_ff;
   assign rsp_evicted_type   = rsp_type_ff;
   assign rsp_evicted_number = rsp_number_ff;
   assign rsp_offset_out     = rsp_offset_ff;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the file handle clock cache.
`timescale 1ns / 100ps

module tb;
   import fhcc_pkg::*;

   localparam int SLOTS        = 16;
   localparam int TYPE_BITS    = 4;
   localparam int NUMBER_BITS  = 36;
   localparam int OFFSET_BITS  = 24;
   localparam int KEY_BITS     = TYPE_BITS + NUMBER_BITS;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 5 * SLOTS + 20;
   localparam int STALL_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 50;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0]   slot_index;
      logic                    was_hit;
      logic                    open_needed;
      logic                    evict_needed;
      logic [TYPE_OUT_W-1:0]   evicted_type;
      logic [NUMBER_OUT_W-1:0] evicted_number;
      logic [OFFSET_OUT_W-1:0] offset_out;
   } access_result_type;

   typedef struct {
      logic [TYPE_BITS-1:0]   file_kind;
      logic [NUMBER_BITS-1:0] file_number;
      logic [OFFSET_BITS-1:0] access_offset;
      logic                   drain_first;
   } file_access_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [TYPE_BITS-1:0]    req_file_kind     = '0;
   logic [NUMBER_BITS-1:0]  req_file_number   = '0;
   logic [OFFSET_BITS-1:0]  req_access_offset = '0;
   logic                    rsp_strobe;
   logic [SLOT_OUT_W-1:0]   rsp_slot_index;
   logic                    rsp_was_hit;
   logic                    rsp_open_needed;
   logic                    rsp_evict_needed;
   logic [TYPE_OUT_W-1:0]   rsp_evicted_type;
   logic [NUMBER_OUT_W-1:0] rsp_evicted_number;
   logic [OFFSET_OUT_W-1:0] rsp_offset_out;

   // Accesses waiting to be issued and outcomes waiting to be strobed
   file_access_type   access_q[$];
   access_result_type outcome_q[$];

   // Shadow copy of the cache contents
   logic [KEY_BITS-1:0] shadow_key [SLOTS];
   flag_type            shadow_flag [SLOTS];
   int                  shadow_hand = 0;

   int n_issued = 0;
   int n_seen = 0;
   int mismatches = 0;
   int stall_cycles = 0;

   file_handle_clock_cache #(
      .SLOTS       (SLOTS),
      .TYPE_BITS   (TYPE_BITS),
      .NUMBER_BITS (NUMBER_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_file_kind      (req_file_kind),
      .req_file_number    (req_file_number),
      .req_access_offset  (req_access_offset),
      .rsp_strobe         (rsp_strobe),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_was_hit        (rsp_was_hit),
      .rsp_open_needed    (rsp_open_needed),
      .rsp_evict_needed   (rsp_evict_needed),
      .rsp_evicted_type   (rsp_evicted_type),
      .rsp_evicted_number (rsp_evicted_number),
      .rsp_offset_out     (rsp_offset_out)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_key[i]  = '0;
         shadow_flag[i] = '0;
      end
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Look the file up in the shadow cache and work out the outcome of the access
   task automatic predict_lookup(input logic [TYPE_BITS-1:0] fkind,
                                 input logic [NUMBER_BITS-1:0] fnum,
                                 input logic [OFFSET_BITS-1:0] fofs,
                                 output access_result_type res);
      logic [KEY_BITS-1:0] key;
      int hit_slot;
      int victim;
      int steps;
      int i;
      key = {fkind, fnum};
      res = '0;
      res.offset_out = fofs;
      hit_slot = -1;
      victim = -1;
      for (i = 0; i < SLOTS; i++)
         if (hit_slot < 0 && shadow_flag[i] != 2'd0 && shadow_key[i] == key)
            hit_slot = i;
      if (hit_slot >= 0) begin
         // hit: mark used, hand stays
         shadow_flag[hit_slot] = FLAG_USED;
         res.slot_index = hit_slot[SLOT_OUT_W-1:0];
         res.was_hit = 1'b1;
      end else begin
         // search from the hand for an empty slot
         for (i = 0; i < SLOTS; i++) begin
            if (victim < 0) begin
               if (shadow_flag[shadow_hand] == 2'd0)
                  victim = shadow_hand;
               else
                  shadow_hand = (shadow_hand + 1) % SLOTS;
            end
         end
         res.open_needed = 1'b1;
         if (victim < 0) begin
            // second chance: age used slots until a not recently used one turns up
            steps = 0;
            while (steps < 3 * SLOTS && shadow_flag[shadow_hand] != FLAG_UNUSED) begin
               shadow_flag[shadow_hand] = shadow_flag[shadow_hand] - 2'd1;
               shadow_hand = (shadow_hand + 1) % SLOTS;
               steps++;
            end
            victim = shadow_hand;
            res.evict_needed = 1'b1;
            res.evicted_type = shadow_key[victim][KEY_BITS-1 -: TYPE_BITS];
            res.evicted_number = shadow_key[victim][NUMBER_BITS-1:0];
         end
         shadow_key[victim]  = key;
         shadow_flag[victim] = FLAG_USED;
         shadow_hand = (victim + 1) % SLOTS;
         res.slot_index = victim[SLOT_OUT_W-1:0];
      end
   endtask

   // Driver: issue queued accesses, predict each one as it is taken
   always @(posedge clock) begin
      access_result_type outcome;
      logic took;
      logic drained;
      logic idle;
      took = start && !busy;
      drained = !took && (n_issued == n_seen + int'(rsp_strobe));
      idle = !(n_issued >= 450 && n_issued < 650) && ($urandom_range(99) < 24);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took) begin
            predict_lookup(req_file_kind, req_file_number, req_access_offset, outcome);
            outcome_q.push_back(outcome);
            void'(access_q.pop_front());
            n_issued++;
         end
         if (start && !took) begin
            // hold the item until it is taken
         end else if (access_q.size() != 0 && !idle &&
                      (!access_q[0].drain_first || drained)) begin
            start <= 1'b1;
            req_file_kind     <= access_q[0].file_kind;
            req_file_number   <= access_q[0].file_number;
            req_access_offset <= access_q[0].access_offset;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each strobed result with the oldest predicted outcome
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_strobe) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("result with no access pending, slot", 64'(rsp_slot_index), 0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_slot_index !== want.slot_index)
               report_mismatch("slot_index", 64'(rsp_slot_index), 64'(want.slot_index));
            if (rsp_was_hit !== want.was_hit)
               report_mismatch("was_hit", 64'(rsp_was_hit), 64'(want.was_hit));
            if (rsp_open_needed !== want.open_needed)
               report_mismatch("open_needed", 64'(rsp_open_needed), 64'(want.open_needed));
            if (rsp_evict_needed !== want.evict_needed)
               report_mismatch("evict_needed", 64'(rsp_evict_needed),
                               64'(want.evict_needed));
            if (rsp_evicted_type !== want.evicted_type)
               report_mismatch("evicted_type", 64'(rsp_evicted_type),
                               64'(want.evicted_type));
            if (rsp_evicted_number !== want.evicted_number)
               report_mismatch("evicted_number", 64'(rsp_evicted_number),
                               64'(want.evicted_number));
            if (rsp_offset_out !== want.offset_out)
               report_mismatch("offset_out", 64'(rsp_offset_out), 64'(want.offset_out));
            n_seen <= n_seen + 1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_access(input logic [TYPE_BITS-1:0] fkind,
                              input logic [NUMBER_BITS-1:0] fnum,
                              input logic [OFFSET_BITS-1:0] fofs,
                              input logic drain);
      file_access_type item;
      item.file_kind     = fkind;
      item.file_number   = fnum;
      item.access_offset = fofs;
      item.drain_first   = drain;
      access_q.push_back(item);
   endtask

   // Stimulus, reset and end of run
   initial begin
      logic [KEY_BITS-1:0]    key_pool[$];
      logic [KEY_BITS-1:0]    key;
      logic [63:0]            raw;
      logic [OFFSET_BITS-1:0] ofs;
      int pool_sizes[4];
      int pick;

      // fill the cache: extremes, keys that differ only in type or only in the top number bit
      push_access('0, '0, '0, 1'b0);
      push_access('1, '1, '1, 1'b0);
      push_access('0, '0, '1, 1'b0);
      push_access(4'd1, '0, 24'h000001, 1'b0);
      push_access('0, 36'h8_0000_0000, 24'h800000, 1'b0);
      for (int i = 2; i < 14; i++)
         push_access(i[TYPE_BITS-1:0], 36'h5_5555_5555 ^ NUMBER_BITS'(i),
                     OFFSET_BITS'(i * 24'h111111), 1'b0);
      // hit on a full cache, then evict after aging every slot
      push_access('1, '1, 24'h123456, 1'b0);
      push_access(4'd7, 36'hA_AAAA_AAAA, 24'hABCDEF, 1'b0);
      push_access(4'd8, 36'h0_FFFF_0000, 24'h654321, 1'b0);
      push_access(4'd8, 36'h0_FFFF_0000, '0, 1'b0);
      push_access(4'd9, 36'hF_0000_FFFF, '1, 1'b1);

      // random phases: small working set first, then ones that overflow the cache
      pool_sizes = '{10, 18, 24, 40};
      foreach (pool_sizes[p]) begin
         key_pool.delete();
         for (int k = 0; k < pool_sizes[p]; k++) begin
            raw = {$urandom, $urandom};
            key = raw[KEY_BITS-1:0];
            // some keys share a number with another one and differ in type only
            if (k > 0 && $urandom_range(3) == 0)
               key[NUMBER_BITS-1:0] = key_pool[$urandom_range(k - 1)][NUMBER_BITS-1:0];
            key_pool.push_back(key);
         end
         for (int n = 0; n < 283; n++) begin
            raw = {$urandom, $urandom};
            if ($urandom_range(99) < 80) begin
               pick = $urandom_range(pool_sizes[p] - 1);
               key = key_pool[pick];
            end else begin
               key = raw[KEY_BITS-1:0];
            end
            ofs = OFFSET_BITS'($urandom);
            case ($urandom_range(19))
               0: ofs = '0;
               1: ofs = '1;
               default: ;
            endcase
            push_access(key[KEY_BITS-1 -: TYPE_BITS], key[NUMBER_BITS-1:0], ofs, n == 0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (access_q.size() != 0 || n_seen != n_issued) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (outcome_q.size() != 0)
         report_mismatch("outcomes never strobed, count", 64'(outcome_q.size()), 0);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
